// ===== sv/far_pkg.sv =====
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and operation codes for the fraction arithmetic block.
// ----------------------------------------------------------------------------
package far_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Operand width; result widths follow so that products and sums stay exact
  localparam int unsigned OPERAND_W = 16;
  localparam int unsigned NUM_W     = 2 * OPERAND_W + 1;
  localparam int unsigned DEN_W     = 2 * OPERAND_W;

  localparam int unsigned S_TDATA_W = ((4 * OPERAND_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;

  // Classified job handed from front to back
  typedef struct packed {
    logic              bad;    // error, result fields zero
    logic              zero;   // zero numerator, raw denominator out
    logic              neg;    // result numerator negative
    logic [NUM_W-1:0]  unum;   // numerator magnitude
    logic [DEN_W-1:0]  uden;   // denominator magnitude
    logic [DEN_W-1:0]  rden;   // raw signed denominator
  } job_t;

endpackage

// ===== sv/far_front.sv =====
// ----------------------------------------------------------------------------
// far_front
// Accept a request, form cross products with one multiplier (one multiply a
// cycle) and classify into a job for the reduction back end.
// ----------------------------------------------------------------------------
module far_front #(
  parameter int unsigned OperandWidth = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                op_i,
  input  logic [OperandWidth-1:0]   a_num_i,
  input  logic [OperandWidth-1:0]   a_den_i,
  input  logic [OperandWidth-1:0]   b_num_i,
  input  logic [OperandWidth-1:0]   b_den_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output far_pkg::job_t             job_o
);
  import far_pkg::*;

  localparam int unsigned PW = 2 * OperandWidth;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M0   = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_CLS  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [1:0]                     op_q;
  logic signed [OperandWidth-1:0] an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0]           p0_q, p1_q, p2_q;
  job_t                           job_q;

  logic signed [OperandWidth-1:0] ma, mb;
  logic signed [PW-1:0]           prod;
  logic signed [PW:0]             num_c;
  logic signed [PW-1:0]           den_c;
  logic [PW:0]                    unum_c;
  logic [PW-1:0]                  uden_c;

  assign in_ready_o  = (state_q == S_IDLE);
  assign job_valid_o = (state_q == S_OUT);
  assign job_o       = job_q;

  // Multiplier operand select per step
  always_comb begin
    ma = an_q;
    mb = bd_q;
    unique case (state_q)
      S_M0: begin ma = an_q; mb = (op_q == OP_MUL) ? bn_q : bd_q; end
      S_M1: begin ma = ad_q; mb = (op_q == OP_DIV) ? bn_q : bd_q; end
      S_M2: begin ma = ad_q; mb = bn_q; end
      default: begin ma = an_q; mb = bd_q; end
    endcase
  end
  assign prod = PW'(ma * mb);

  always_comb begin
    case (op_q)
      OP_ADD:  num_c = {p0_q[PW-1], p0_q} + {p2_q[PW-1], p2_q};
      OP_SUB:  num_c = {p0_q[PW-1], p0_q} - {p2_q[PW-1], p2_q};
      default: num_c = {p0_q[PW-1], p0_q};
    endcase
    den_c = p1_q;
  end

  assign unum_c = num_c[PW] ? (PW+1)'(-num_c) : num_c;
  assign uden_c = den_c[PW-1] ? PW'(-den_c) : den_c;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_M0;
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_CLS;
      S_CLS:  state_d = S_OUT;
      S_OUT:  if (job_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q <= op_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    if (state_q == S_M0) p0_q <= prod;
    if (state_q == S_M1) p1_q <= prod;
    if (state_q == S_M2) begin
      p2_q  <= prod;
    end
    // Build the whole job here so it is complete on the first S_OUT cycle
    if (state_q == S_CLS) begin
      job_q.bad  <= (ad_q == '0) || (bd_q == '0) || (den_c == '0);
      job_q.zero <= (num_c == '0);
      job_q.neg  <= num_c[PW] ^ den_c[PW-1];
      job_q.rden <= DEN_W'(den_c);
      job_q.unum <= NUM_W'(unum_c);
      job_q.uden <= DEN_W'(uden_c);
    end
  end
endmodule

// ===== sv/far_queue.sv =====
// ----------------------------------------------------------------------------
// far_queue
// Two-entry queue between classifier and reduction engine.
// ----------------------------------------------------------------------------
module far_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  far_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output far_pkg::job_t rd_data_o
);
  import far_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// ===== sv/far_back.sv =====
// ----------------------------------------------------------------------------
// far_back
// Euclidean reduction with a shared restoring divider (one quotient bit a
// cycle), then divide numerator and denominator by the divisor found.
// ----------------------------------------------------------------------------
module far_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  far_pkg::job_t job_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [far_pkg::NUM_W-1:0] res_num_o,
  output logic [far_pkg::DEN_W-1:0] res_den_o,
  output logic          res_bad_o
);
  import far_pkg::*;

  localparam int unsigned W  = NUM_W;
  localparam int unsigned CW = $clog2(W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DN   = 3'd2;
  localparam logic [2:0] S_DD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic          div_busy_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  dvd_q, dvs_q, quo_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  x_q, y_q, g_q, unum_q, uden_q;
  logic          neg_q;
  logic [NUM_W-1:0] onum_q;
  logic [DEN_W-1:0] oden_q;
  logic          obad_q;

  logic [W:0]    trial;
  logic          fits;
  logic [W:0]    rem_n;
  logic [W-1:0]  quo_n;
  logic          div_done;

  assign job_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_num_o   = onum_q;
  assign res_den_o   = oden_q;
  assign res_bad_o   = obad_q;

  assign trial    = {rem_q[W-1:0], dvd_q[W-1]};
  assign fits     = (trial >= {1'b0, dvs_q});
  assign rem_n    = fits ? trial - {1'b0, dvs_q} : trial;
  assign quo_n    = {quo_q[W-2:0], fits};
  assign div_done = div_busy_q && (cnt_q == CW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          state_d = (job_i.bad || job_i.zero) ? S_OUT : S_GCD;
        end
      end
      S_GCD: if (div_done && rem_n == '0) state_d = S_DN;
      S_DN:  if (div_done) state_d = S_DD;
      S_DD:  if (div_done) state_d = S_OUT;
      S_OUT: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      div_busy_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && job_valid_i && !job_i.bad && !job_i.zero) begin
        div_busy_q <= 1'b1;
        cnt_q      <= CW'(W);
      end else if (div_busy_q) begin
        if (cnt_q == CW'(1)) begin
          // start next division unless finishing the last one
          div_busy_q <= !(state_q == S_DD);
          cnt_q      <= CW'(W);
        end else begin
          cnt_q <= cnt_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && job_valid_i) begin
      neg_q  <= job_i.neg;
      obad_q <= job_i.bad;
      onum_q <= '0;
      oden_q <= job_i.bad ? '0 : job_i.rden;
      unum_q <= job_i.unum;
      uden_q <= W'(job_i.uden);
      x_q    <= job_i.unum;
      y_q    <= W'(job_i.uden);
      dvd_q  <= job_i.unum;
      dvs_q  <= W'(job_i.uden);
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (div_busy_q) begin
      if (cnt_q == CW'(1)) begin
        rem_q <= '0;
        quo_q <= '0;
        unique case (state_q)
          S_GCD: begin
            if (rem_n == '0) begin
              g_q   <= dvs_q;
              dvd_q <= unum_q;
            end else begin
              dvd_q <= dvs_q;
              dvs_q <= rem_n[W-1:0];
            end
          end
          S_DN: begin
            onum_q <= neg_q ? NUM_W'(-quo_n) : NUM_W'(quo_n);
            dvd_q  <= uden_q;
            dvs_q  <= g_q;
          end
          S_DD: oden_q <= DEN_W'(quo_n);
          default: ;
        endcase
        if (state_q == S_GCD && rem_n == '0) dvs_q <= dvs_q;
      end else begin
        rem_q <= rem_n;
        quo_q <= quo_n;
        dvd_q <= {dvd_q[W-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== sv/fraction_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce
// Exact rational add, subtract, multiply and divide with reduction by the
// greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = req_type, tdata = a_num, a_den,
//   b_num, b_den from the lowest bit up. m_axis returns one result per
//   request: tdata = res_num, res_den; tuser = bad_denominator.
//   The front end takes a request, forms the cross products with one
//   multiplier and classifies it (error, zero numerator, sign). A
//   two-entry queue hands the job to the back end. The back end runs
//   Euclid with one restoring divider, then two more divisions for
//   numerator and denominator. A request with an error or a zero
//   numerator skips the divider. The back end takes one request at a
//   time, the front end running ahead.
//   Reset clears all control state; no clearing pass is needed.
//   A stalled m_axis holds its result; the queue then fills and s_axis
//   tready drops.
// ----------------------------------------------------------------------------
module fraction_arith_reduce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // a_num, a_den, b_num, b_den from bit 0 up
  input  logic [far_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  logic [1:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // res_num (33), res_den (32) from bit 0 up, zero filled
  output logic [far_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // bad_denominator
  output logic                       m_axis_tuser
);
  import far_pkg::*;

  localparam int unsigned OW = OPERAND_W;

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  job_t          fj, bj;
  logic [NUM_W-1:0] rnum;
  logic [DEN_W-1:0] rden;

  far_front #(.OperandWidth(OW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .a_num_i    (s_axis_tdata[OW-1:0]),
    .a_den_i    (s_axis_tdata[2*OW-1:OW]),
    .b_num_i    (s_axis_tdata[3*OW-1:2*OW]),
    .b_den_i    (s_axis_tdata[4*OW-1:3*OW]),
    .job_valid_o(fj_valid),
    .job_ready_i(fj_ready),
    .job_o      (fj)
  );

  // Decouple classification from reduction
  far_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  far_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_num_o(rnum), .res_den_o(rden), .res_bad_o(m_axis_tuser)
  );

  assign m_axis_tdata = M_TDATA_W'({rden, rnum});
endmodule

// ===== test/fraction_arith_reduce_tb.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce_tb
// Self-checking bench for the fraction arithmetic block: a directed table of
// requests, then random requests under idling and stalling phases and a hold-off,
// each result compared with its typed-in value or a local rational predictor.
// ----------------------------------------------------------------------------
module fraction_arith_reduce_tb;
  import far_pkg::*;

  localparam int unsigned OW = OPERAND_W;
  localparam int unsigned TDW = S_TDATA_W;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             bad;
  } frac_res_t;

  typedef struct {
    logic [1:0]        op;
    logic signed [15:0] an, ad, bn, bd;
    logic              known;   // expected result typed in
    frac_res_t         res;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [TDW-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;

  frac_res_t pending_q[$];
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  fraction_arith_reduce uut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  // Rational result of one request
  function automatic frac_res_t reduce_frac(logic [1:0] op, logic signed [15:0] an,
                                            logic signed [15:0] ad, logic signed [15:0] bn,
                                            logic signed [15:0] bd);
    longint n, d;
    longint unsigned un, ud, g;
    frac_res_t r;
    r = '0;
    if (ad == 0 || bd == 0) begin
      r.bad = 1'b1;
      return r;
    end
    case (op)
      OP_ADD: begin n = an*bd + ad*bn; d = ad*bd; end
      OP_SUB: begin n = an*bd - ad*bn; d = ad*bd; end
      OP_MUL: begin n = an*bn; d = ad*bd; end
      default: begin n = an*bd; d = ad*bn; end
    endcase
    if (d == 0) begin
      r.bad = 1'b1;
      return r;
    end
    if (n == 0) begin
      r.den = d[DEN_W-1:0];
      return r;
    end
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    g = gcd_of(un, ud);
    un = un / g;
    ud = ud / g;
    if ((n < 0) != (d < 0)) un = -un;
    r.num = un[NUM_W-1:0];
    r.den = ud[DEN_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    err_cnt++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
  endtask

  // Offer one request and hold it until accepted; drop tvalid only while idling
  task automatic send_request(logic [1:0] op, logic signed [15:0] an,
                              logic signed [15:0] ad, logic signed [15:0] bn,
                              logic signed [15:0] bd, frac_res_t exp);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bd, ad, bn, an} == 0 ? '0 : TDW'({bd, bn, ad, an});
    pending_q.push_back(exp);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall, or held off by the pressure phase
  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker, sampled at the edge on pre-edge values
  always @(posedge clk_i) begin
    frac_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[32:0], 0);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[32:0] !== e.num)
          report_mismatch("res_num", m_axis_tdata[32:0], e.num);
        if (m_axis_tdata[64:33] !== e.den)
          report_mismatch("res_den", m_axis_tdata[64:33], e.den);
        if (m_axis_tuser !== e.bad)
          report_mismatch("bad_denominator", m_axis_tuser, e.bad);
      end
    end
  end

  function automatic logic signed [15:0] rand_operand();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sd0;
      3, 4: return 16'($signed($urandom_range(15)) - 8);
      5, 6: return 16'($signed($urandom_range(255)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    frac_res_t e;
    logic signed [15:0] an, ad, bn, bd;
    logic [1:0] op;
    int n;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADD;
    m_axis_tready = 0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed table: op, a_num, a_den, b_num, b_den, known, expected
    rows = '{
      '{OP_ADD, 1, 2, 1, 3, 1, '{33'd5, 32'd6, 1'b0}},
      '{OP_SUB, 1, 2, 1, 3, 1, '{33'd1, 32'd6, 1'b0}},
      '{OP_MUL, 2, 3, 3, 4, 1, '{33'd1, 32'd2, 1'b0}},
      '{OP_DIV, 1, 2, 1, 4, 1, '{33'd2, 32'd1, 1'b0}},
      '{OP_ADD, 1, 0, 1, 3, 1, '{33'd0, 32'd0, 1'b1}},
      '{OP_MUL, 1, 2, 1, 0, 1, '{33'd0, 32'd0, 1'b1}},
      '{OP_DIV, 1, 2, 0, 5, 1, '{33'd0, 32'd0, 1'b1}},
      '{OP_SUB, 1, 2, 1, 2, 1, '{33'd0, 32'd4, 1'b0}},
      '{OP_MUL, 0, -3, 5, 7, 1, '{33'd0, -32'sd21, 1'b0}},
      '{OP_ADD, -1, 2, 0, -1, 1, '{-33'sd1, 32'd2, 1'b0}},
      '{OP_MUL, 16'sh8000, 1, 16'sh8000, 1, 0, '0},
      '{OP_ADD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0, '0},
      '{OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, '0},
      '{OP_DIV, 16'sh8000, 16'sh7fff, 16'sh8000, -1, 0, '0},
      '{OP_MUL, -1, -1, -1, -1, 0, '0},
      '{OP_DIV, 16'sh7fff, 16'sh7ffe, 16'sh7ffd, 16'sh7fff, 0, '0},
      '{OP_ADD, -7, 16'sh8000, 3, 16'sh8000, 0, '0},
      '{OP_SUB, 16'shffff, 16'shffff, 16'shaaaa, 16'sh5555, 0, '0}
    };
    foreach (rows[i]) begin
      row = rows[i];
      e = row.known ? row.res : reduce_frac(row.op, row.an, row.ad, row.bn, row.bd);
      send_request(row.op, row.an, row.ad, row.bn, row.bd, e);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // random phases: none, sender idle, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 8 : 0;
      recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 8 : 0;
      for (n = 0; n < 180; n++) begin
        op = 2'($urandom);
        an = rand_operand(); ad = rand_operand();
        bn = rand_operand(); bd = rand_operand();
        if ($urandom_range(9) != 0 && ad == 0) ad = 1;
        if ($urandom_range(9) != 0 && bd == 0) bd = -1;
        send_request(op, an, ad, bn, bd, reduce_frac(op, an, ad, bn, bd));
      end
      // pause until every result is back
      s_axis_tvalid <= 1'b0;
      wait_drained();
    end

    // hold the receiver off so the queue fills and the input stalls
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        for (n = 0; n < 10; n++) begin
          op = 2'($urandom);
          an = rand_operand(); ad = 16'($urandom_range(100) + 1);
          bn = rand_operand(); bd = 16'($urandom_range(100) + 1);
          send_request(op, an, ad, bn, bd, reduce_frac(op, an, ad, bn, bd));
        end
        s_axis_tvalid <= 1'b0;
      end
    join
    stim_done = 1;
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/far_pkg.sv
sv/far_front.sv
sv/far_queue.sv
sv/far_back.sv
sv/fraction_arith_reduce.sv
test/fraction_arith_reduce_tb.sv
